// ----- src/assert_macros.svh -----
// assertion macros shared by the task deque modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define PTD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/ptd_pkg.sv -----
// shared types and constants for the per-core task deque
package ptd_pkg;

  // default sizes
  localparam int MAX_CORES_DEF = 16;
  localparam int MAX_TASKS_DEF = 256;

  // field widths
  localparam int CORE_COUNT_W = 5;
  localparam int CMD_W        = 2;
  localparam int ID_W         = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  core_index;
    logic [ID_W-1:0]  task_id;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [ID_W-1:0] popped_task;
    logic            popped_valid;
    logic            queue_empty;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the accepted word
    logic nil_wr;      // next_link[task] = nil (push back)
    logic back_first;  // push back into an empty queue
    logic link_wr;     // next_link[tail] = task, tail = task
    logic front_wr;    // next_link[task] = head, head = task
    logic pop_rd;      // read next_link[head]
    logic pop_commit;  // head = next, next_link[old head] = nil
    logic load;        // load the output register
  } ptd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_back;
    logic is_front;
    logic is_pop;
    logic head_valid;
    logic tail_valid;
    logic out_free;
  } ptd_sts_t;

endpackage

// ----- src/ptd_ram.sv -----
// generic single write port ram with registered read
module ptd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/ptd_ctrl.sv -----
// controller state machine for the per-core task deque
`include "assert_macros.svh"

module ptd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptd_pkg::ptd_sts_t sts,
  output ptd_pkg::ptd_cmd_t cmd
);
  import ptd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_POPW
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (sts.is_back) begin
          cmd.nil_wr = 1'b1;
          if (sts.tail_valid) begin
            state_nxt = S_LINK;
          end else if (sts.out_free) begin
            cmd.back_first = 1'b1;
            cmd.load       = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.is_front) begin
          if (sts.out_free) begin
            cmd.front_wr = 1'b1;
            cmd.load     = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.is_pop && sts.head_valid) begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POPW;
        end else begin
          // empty pop or a word that changes nothing
          if (sts.out_free) begin
            cmd.load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_LINK: begin
        if (sts.out_free) begin
          cmd.link_wr = 1'b1;
          cmd.load    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_POPW: begin
        if (sts.out_free) begin
          cmd.pop_commit = 1'b1;
          cmd.load       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  `PTD_ASSERT(a_load_into_free_slot, cmd.load |-> sts.out_free, "result loaded over a held word")
  `PTD_ASSERT(a_accept_starts_exec, (in_valid && in_ready) |=> (state_r == S_EXEC),
    "accepted word did not start execution")
  `PTD_NEVER(a_pop_read_needs_head, cmd.pop_rd && !sts.head_valid, "pop read of an empty queue")

endmodule

// ----- src/ptd_dp.sv -----
// datapath: queue heads and tails, link store and output register
`include "assert_macros.svh"

module ptd_dp #(
  parameter int MAX_CORES = ptd_pkg::MAX_CORES_DEF,
  parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ptd_pkg::in_word_t                 in_data,
  input  logic                              cfg_we,
  input  logic [ptd_pkg::CORE_COUNT_W-1:0]  cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ptd_pkg::out_word_t                out_data,
  input  ptd_pkg::ptd_cmd_t                 cmd,
  output ptd_pkg::ptd_sts_t                 sts
);
  import ptd_pkg::*;

  localparam int LW = $clog2(MAX_TASKS + 1);
  localparam int TW = $clog2(MAX_TASKS);
  localparam int QW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int XW = ID_W + 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);

  logic [CORE_COUNT_W-1:0] core_count_r;
  logic [CMD_W-1:0]        op_r;
  logic [QW-1:0]           q_r;
  logic [ID_W-1:0]         tid_r;
  logic                    tid_ok_r;
  logic [LW-1:0]           head_r [MAX_CORES];
  logic [LW-1:0]           tail_r [MAX_CORES];
  logic                    out_valid_r;
  out_word_t               out_r;

  logic [QW-1:0] q_sel;
  logic          tid_ok;
  logic [LW-1:0] head_cur, tail_cur, head_new, tail_new;
  logic [LW-1:0] tid_link, nx_raw, nx;
  logic          ram_we;
  logic [TW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  out_word_t     res;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_count_r <= CORE_COUNT_W'(1);
    end else if (cfg_we) begin
      core_count_r <= cfg_wdata;
    end
  end

  // queue select and task range check on the incoming word
  assign q_sel  = ((XW'(in_data.core_index) < XW'(core_count_r)) &&
                   (XW'(in_data.core_index) < XW'(MAX_CORES))) ?
                  QW'(in_data.core_index) : '0;
  assign tid_ok = {{LW{1'b0}}, in_data.task_id} < (LW + ID_W)'(MAX_TASKS);

  // word capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (cmd.capture) begin
      q_r <= q_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_data.cmd;
      tid_r    <= in_data.task_id;
      tid_ok_r <= tid_ok;
    end
  end

  assign head_cur = head_r[q_r];
  assign tail_cur = tail_r[q_r];
  assign tid_link = LW'(tid_r);

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.is_back    = (op_r == CMD_PUSH_BACK) && tid_ok_r;
    sts.is_front   = (op_r == CMD_PUSH_FRONT) && tid_ok_r;
    sts.is_pop     = (op_r == CMD_POP_FRONT);
    sts.head_valid = head_cur < NIL;
    sts.tail_valid = tail_cur < NIL;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // link store
  ptd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_TASKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.pop_rd),
    .rd_addr (head_cur[TW-1:0]),
    .rd_data (nx_raw)
  );

  // clamp a link beyond nil
  assign nx = (nx_raw > NIL) ? NIL : nx_raw;

  // link write select
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = TW'(tid_r);
    ram_wdata = NIL;
    priority if (cmd.nil_wr) begin
      ram_waddr = TW'(tid_r);
      ram_wdata = NIL;
    end else if (cmd.link_wr) begin
      ram_waddr = tail_cur[TW-1:0];
      ram_wdata = tid_link;
    end else if (cmd.front_wr) begin
      ram_waddr = TW'(tid_r);
      ram_wdata = head_cur;
    end else if (cmd.pop_commit) begin
      ram_waddr = head_cur[TW-1:0];
      ram_wdata = NIL;
    end else begin
      ram_we = 1'b0;
    end
  end

  // new head and tail of the selected queue
  always_comb begin
    head_new = head_cur;
    tail_new = tail_cur;
    priority if (cmd.back_first) begin
      head_new = tid_link;
      tail_new = tid_link;
    end else if (cmd.link_wr) begin
      tail_new = tid_link;
    end else if (cmd.front_wr) begin
      head_new = tid_link;
      if (tail_cur >= NIL) begin
        tail_new = tid_link;
      end
    end else if (cmd.pop_commit) begin
      head_new = nx;
      if (nx >= NIL) begin
        tail_new = NIL;
      end
    end else begin
      head_new = head_cur;
    end
  end

  // head and tail registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CORES; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
    end else begin
      head_r[q_r] <= head_new;
      tail_r[q_r] <= tail_new;
    end
  end

  // result word
  always_comb begin
    res              = '0;
    res.popped_task  = cmd.pop_commit ? ID_W'(head_cur) : '0;
    res.popped_valid = cmd.pop_commit;
    res.queue_empty  = head_new >= NIL;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `PTD_ASSERT(a_head_tail_agree, (head_cur >= NIL) == (tail_cur >= NIL),
    "selected queue has head and tail out of step")
  `PTD_ASSERT(a_head_in_range, head_cur <= NIL, "queue head beyond nil")
  `PTD_NEVER(a_pop_from_empty, cmd.pop_commit && (head_cur >= NIL), "pop committed on empty queue")

endmodule

// ----- src/per_core_task_deque_top.sv -----
// per-core task deque: one linked task queue per core over a shared link store
//
// Input channel in_valid/in_ready carries one word: cmd (push back, push
// front, pop front), core_index and task_id. Every word gives exactly one
// result word on out_valid/out_ready: popped_task, popped_valid and
// queue_empty for the selected queue after the operation.
// cfg_we/cfg_wdata write core_count; indices not below it or MAX_CORES select queue 0.
// Push front, an empty push back, an empty pop or an unused command load
// the result from the execute state; a push back onto a non-empty queue
// (second link write, link state) and a pop (registered read of the head's
// link from the link ram, pop wait state) load it from a following state.
// A new word is taken the cycle after the result is loaded, and not before.
// The result sits in an output register; the next word is accepted while
// it waits. If the receiver stalls, a finished word holds in its last
// step until the output register frees up.
// Reset empties every queue and sets core_count to 1; the link ram needs
// no clearing, as entries are written before any read.
module per_core_task_deque_top #(
  parameter int MAX_CORES = ptd_pkg::MAX_CORES_DEF,
  parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ptd_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ptd_pkg::out_word_t               out_data,
  input  logic                             cfg_we,
  input  logic [ptd_pkg::CORE_COUNT_W-1:0] cfg_wdata
);
  import ptd_pkg::*;

  ptd_cmd_t cmd;
  ptd_sts_t sts;

  // controller
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  ptd_dp #(
    .MAX_CORES (MAX_CORES),
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- test/task_deque_check_pkg.sv -----
// tracking model and result checker for the per-core task deque testbench
`timescale 1ns / 1ps

package task_deque_check_pkg;
  import ptd_pkg::*;

  localparam int          N_QUEUES = MAX_CORES_DEF;
  localparam int          N_TASKS  = MAX_TASKS_DEF;
  localparam logic [8:0]  NIL      = 9'(MAX_TASKS_DEF);
  localparam int          SHOW_MAX = 10;

  class deque_tracker;
    logic [8:0]              link_q[N_TASKS];
    logic [8:0]              head_q[N_QUEUES];
    logic [8:0]              tail_q[N_QUEUES];
    logic [CORE_COUNT_W-1:0] core_count;
    bit                      queued[N_TASKS];
    int                      occupancy;
    out_word_t               expected_words[$];
    int                      mismatches;

    function new();
      for (int i = 0; i < N_TASKS; i++) begin
        link_q[i] = NIL;
        queued[i] = 1'b0;
      end
      for (int i = 0; i < N_QUEUES; i++) begin
        head_q[i] = NIL;
        tail_q[i] = NIL;
      end
      core_count = 1;
      occupancy  = 0;
      mismatches = 0;
    endfunction

    function void set_core_count(logic [CORE_COUNT_W-1:0] v);
      core_count = v;
    endfunction

    // out-of-range core index falls back to queue zero
    function int unsigned queue_of(logic [ID_W-1:0] idx);
      if (idx < core_count && idx < N_QUEUES)
        return idx;
      return 0;
    endfunction

    // apply one accepted command word and store the word it should produce
    function void note_command(in_word_t w);
      int unsigned q;
      logic [8:0]  t;
      logic [8:0]  h;
      logic [8:0]  nx;
      out_word_t   r;
      q = queue_of(w.core_index);
      t = {1'b0, w.task_id};
      r = '0;
      case (w.cmd)
        CMD_PUSH_BACK: begin
          link_q[t] = NIL;
          if (tail_q[q] != NIL)
            link_q[tail_q[q]] = t;
          else
            head_q[q] = t;
          tail_q[q] = t;
          if (!queued[t]) begin
            queued[t] = 1'b1;
            occupancy++;
          end
        end
        CMD_PUSH_FRONT: begin
          link_q[t] = head_q[q];
          head_q[q] = t;
          if (tail_q[q] == NIL)
            tail_q[q] = t;
          if (!queued[t]) begin
            queued[t] = 1'b1;
            occupancy++;
          end
        end
        CMD_POP_FRONT: begin
          h = head_q[q];
          if (h != NIL) begin
            nx = link_q[h];
            head_q[q] = nx;
            if (nx == NIL)
              tail_q[q] = NIL;
            link_q[h] = NIL;
            r.popped_task  = h[ID_W-1:0];
            r.popped_valid = 1'b1;
            if (queued[h]) begin
              queued[h] = 1'b0;
              occupancy--;
            end
          end
        end
        default: ;
      endcase
      r.queue_empty = (head_q[q] == NIL);
      expected_words.push_back(r);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result word: task %0d valid %0d empty %0d",
                   got.popped_task, got.popped_valid, got.queue_empty);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.popped_task !== exp_w.popped_task ||
          got.popped_valid !== exp_w.popped_valid ||
          got.queue_empty !== exp_w.queue_empty) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("result mismatch: expected task %0d valid %0d empty %0d, got task %0d valid %0d empty %0d",
                   exp_w.popped_task, exp_w.popped_valid, exp_w.queue_empty,
                   got.popped_task, got.popped_valid, got.queue_empty);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function int failures();
      return mismatches + expected_words.size();
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
// testbench top for the per-core task deque: directed and random command words
`timescale 1ns / 1ps

module tb;
  import ptd_pkg::*;
  import task_deque_check_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               WORDS_PER_PHASE = 220;
  localparam int               HOLD_CYCLES = 400;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_word_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [CORE_COUNT_W-1:0] cfg_wdata = '0;

  deque_tracker            sb = new();
  bit                      steady = 1'b0;
  bit                      hold_req = 1'b0;
  int                      hold_left = 0;

  per_core_task_deque_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // run limit
  initial begin
    #4000000;
    $display("per_core_task_deque_top regression: fail");
    $finish;
  end

  // result side: check accepted words, random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_word(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 16);
    end
  end

  // offer one word, with random idle cycles first, and wait for acceptance
  task automatic send(input in_word_t w);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_command(w);
  endtask

  // drop valid, let the block drain, then write core_count
  task automatic write_core_count(input logic [CORE_COUNT_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_core_count(v);
  endtask

  // mostly well-formed pushes of free tasks and pops, some raw noise
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned eff;
    bit          do_pop;
    if ($urandom_range(9) == 0) begin
      w = in_word_t'(18'($urandom));
      return w;
    end
    eff = (sb.core_count == 0) ? 1 : (sb.core_count > N_QUEUES) ? N_QUEUES : sb.core_count;
    w.core_index = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(eff - 1));
    if (sb.occupancy == 0)
      do_pop = 1'b0;
    else if (sb.occupancy >= 250)
      do_pop = 1'b1;
    else if (sb.occupancy > 160)
      do_pop = ($urandom_range(99) < 75);
    else
      do_pop = ($urandom_range(99) < 45);
    if (do_pop) begin
      w.cmd     = CMD_POP_FRONT;
      w.task_id = 8'($urandom);
    end else begin
      w.cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      do w.task_id = 8'($urandom); while (sb.queued[w.task_id]);
    end
    return w;
  endfunction

  initial begin
    logic [CORE_COUNT_W-1:0] settings[8];
    settings = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd9, 5'd16, 5'd3, 5'd17};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset core count of one: everything lands in queue zero
    send('{CMD_POP_FRONT,  8'd0,   8'd0});
    send('{CMD_PUSH_BACK,  8'd255, 8'd0});
    send('{CMD_PUSH_FRONT, 8'd1,   8'd255});
    send('{CMD_UNUSED,     8'd0,   8'hAA});
    send('{CMD_POP_FRONT,  8'd0,   8'd0});
    send('{CMD_POP_FRONT,  8'd200, 8'hFF});
    send('{CMD_POP_FRONT,  8'd0,   8'd0});

    // directed, core count of sixteen so all sixteen queues are selectable
    write_core_count(5'd16);
    send('{CMD_PUSH_BACK,  8'd15, 8'h55});
    send('{CMD_PUSH_BACK,  8'd15, 8'hAA});
    send('{CMD_PUSH_FRONT, 8'd15, 8'h01});
    send('{CMD_PUSH_BACK,  8'd16, 8'h80});
    send('{CMD_UNUSED,     8'd15, 8'h00});
    send('{CMD_POP_FRONT,  8'd15, 8'h00});
    send('{CMD_POP_FRONT,  8'd15, 8'h00});
    send('{CMD_POP_FRONT,  8'd15, 8'h00});
    send('{CMD_POP_FRONT,  8'd15, 8'h00});
    send('{CMD_POP_FRONT,  8'd0,  8'h00});
    // same task pushed twice: the chain loops on itself
    send('{CMD_PUSH_BACK,  8'd3,  8'd7});
    send('{CMD_PUSH_BACK,  8'd3,  8'd7});
    send('{CMD_POP_FRONT,  8'd3,  8'd0});
    send('{CMD_POP_FRONT,  8'd3,  8'd0});
    send('{CMD_POP_FRONT,  8'd3,  8'd0});
    send('{CMD_PUSH_FRONT, 8'd8,  8'hFE});
    send('{CMD_POP_FRONT,  8'd8,  8'hFF});

    // random phases over several core counts
    foreach (settings[p]) begin
      write_core_count(settings[p]);
      steady = (p == 2);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ((p == 1 || p == 5) && i == 50)
          hold_req = 1'b1;
        send(random_word());
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain and settle
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures() == 0)
      $display("per_core_task_deque_top regression: pass");
    else
      $display("per_core_task_deque_top regression: fail");
    $finish;
  end

endmodule
